// File: hdl/chd_pkg.sv
// ----------------------------------------------------------------------------
// chd_pkg
// Types, codes and constants shared by the chunked body decoder modules.
// ----------------------------------------------------------------------------
package chd_pkg;

  // Width of a chunk size; larger values are reported as size overflow.
  localparam int SIZE_BITS = 32;

  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_SEMI = 8'h3b;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_OK      = 2'd1;
  localparam logic [1:0] KIND_BAD     = 2'd2;

  localparam logic [2:0] FAULT_NONE      = 3'd0;
  localparam logic [2:0] FAULT_BAD_SIZE  = 3'd1;
  localparam logic [2:0] FAULT_OVERFLOW  = 3'd2;
  localparam logic [2:0] FAULT_DATA_CRLF = 3'd3;
  localparam logic [2:0] FAULT_ZERO_CRLF = 3'd4;
  localparam logic [2:0] FAULT_TRUNCATED = 3'd5;

  // Decoder phases.
  localparam logic [3:0] PH_LINE_START = 4'd0;
  localparam logic [3:0] PH_SIZE_LINE  = 4'd1;
  localparam logic [3:0] PH_DATA       = 4'd2;
  localparam logic [3:0] PH_DATA_CR    = 4'd3;
  localparam logic [3:0] PH_DATA_LF    = 4'd4;
  localparam logic [3:0] PH_ZERO_CR    = 4'd5;
  localparam logic [3:0] PH_ZERO_LF    = 4'd6;
  localparam logic [3:0] PH_DONE       = 4'd7;
  localparam logic [3:0] PH_FAILED     = 4'd8;

  // Outcome of a completed size line.
  localparam logic [1:0] LE_DATA = 2'd0;
  localparam logic [1:0] LE_ZERO = 2'd1;
  localparam logic [1:0] LE_BAD  = 2'd2;
  localparam logic [1:0] LE_OVER = 2'd3;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       end_of_body;
  } in_item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] payload_byte;
    logic [2:0] fault_code;
  } out_item_t;

  // Size line scan flags. A semicolon simply stops the scan.
  typedef struct packed {
    logic digits;
    logic sign;
    logic stop;
    logic neg;
    logic over;
    logic lone_zero;
  } size_flags_t;

  typedef struct packed {
    size_flags_t          flags;
    logic [SIZE_BITS-1:0] acc;
  } line_state_t;

  // Parser result handed to the engine.
  typedef struct packed {
    logic        line_done;
    logic [1:0]  line_code;
    line_state_t lst_nxt;
    logic        crp_nxt;
  } parse_t;

endpackage

// File: hdl/chd_in_stage.sv
// ----------------------------------------------------------------------------
// chd_in_stage
// Input register: holds one accepted item until the engine takes it.
// ----------------------------------------------------------------------------
module chd_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  chd_pkg::in_item_t in_data,
  output logic              stg_valid,
  output chd_pkg::in_item_t stg_item,
  input  logic              stg_take
);
  import chd_pkg::*;

  logic     valid_r, valid_nxt;
  in_item_t item_r, item_nxt;
  logic     in_fire;

  assign in_ready  = !valid_r || stg_take;
  assign in_fire   = in_valid && in_ready;
  assign stg_valid = valid_r;
  assign stg_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (in_fire) begin
      valid_nxt = 1'b1;
      item_nxt  = in_data;
    end else if (stg_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

endmodule

// File: hdl/chd_size_parser.sv
// ----------------------------------------------------------------------------
// chd_size_parser
// Combinational scan of one size line character, with CR LF detection.
// ----------------------------------------------------------------------------
module chd_size_parser (
  input  logic                 [7:0] body_byte,
  input  chd_pkg::line_state_t       lst_r,
  input  logic                       crp_r,
  output chd_pkg::parse_t            pr
);
  import chd_pkg::*;

  function automatic line_state_t line_char(line_state_t s, logic [7:0] c);
    line_state_t o;
    logic        is_hex;
    logic [3:0]  d;
    logic        white;
    o = s;
    is_hex = 1'b0;
    d = 4'd0;
    case (c) inside
      [8'h30:8'h39]: begin
        is_hex = 1'b1;
        d = c[3:0];
      end
      [8'h41:8'h46], [8'h61:8'h66]: begin
        is_hex = 1'b1;
        d = c[3:0] + 4'd9;
      end
      default: begin
        is_hex = 1'b0;
      end
    endcase
    white = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
    if (s.flags.stop) begin
      o = s;
    end else if (c == CH_SEMI) begin
      o.flags.stop = 1'b1;
    end else if (!s.flags.digits) begin
      if (!s.flags.sign && white) begin
        o = s;
      end else if (!s.flags.sign && (c == 8'h2b || c == 8'h2d)) begin
        o.flags.sign = 1'b1;
        o.flags.neg  = (c == 8'h2d);
      end else if (!is_hex) begin
        o.flags.stop = 1'b1;
      end else begin
        o.flags.digits    = 1'b1;
        o.flags.lone_zero = (d == 4'd0);
        o.acc             = {{(SIZE_BITS-4){1'b0}}, d};
      end
    end else if (s.flags.lone_zero && (c == 8'h78 || c == 8'h58)) begin
      // "0x" prefix after a single leading zero.
      o.flags.lone_zero = 1'b0;
    end else begin
      o.flags.lone_zero = 1'b0;
      if (!is_hex) begin
        o.flags.stop = 1'b1;
      end else if (s.flags.over) begin
        o.acc = s.acc;
      end else if (s.acc[SIZE_BITS-1 -: 4] != 4'd0) begin
        o.flags.over = 1'b1;
      end else begin
        o.acc = {s.acc[SIZE_BITS-5:0], d};
      end
    end
    return o;
  endfunction

  line_state_t after_cr;

  always_comb begin
    after_cr     = line_char(lst_r, CH_CR);
    pr.line_done = 1'b0;
    pr.lst_nxt   = lst_r;
    pr.crp_nxt   = 1'b0;
    if (crp_r && body_byte == CH_LF) begin
      pr.line_done = 1'b1;
    end else begin
      // A lone CR belongs to the line and is scanned like any character.
      if (crp_r) begin
        pr.lst_nxt = after_cr;
      end
      if (body_byte == CH_CR) begin
        pr.crp_nxt = 1'b1;
      end else begin
        pr.lst_nxt = line_char(pr.lst_nxt, body_byte);
      end
    end

    if (!lst_r.flags.digits) begin
      pr.line_code = LE_BAD;
    end else if (lst_r.flags.over) begin
      pr.line_code = LE_OVER;
    end else if (lst_r.acc == '0) begin
      pr.line_code = LE_ZERO;
    end else if (lst_r.flags.neg) begin
      pr.line_code = LE_BAD;
    end else begin
      pr.line_code = LE_DATA;
    end
  end

endmodule

// File: hdl/chd_engine.sv
// ----------------------------------------------------------------------------
// chd_engine
// Decoder phase register, chunk byte counter and result register.
// ----------------------------------------------------------------------------
module chd_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               stg_valid,
  input  chd_pkg::in_item_t  stg_item,
  output logic               stg_take,
  input  chd_pkg::parse_t    pr,
  output chd_pkg::line_state_t lst,
  output logic               crp,
  output logic               out_valid,
  input  logic               out_ready,
  output chd_pkg::out_item_t out_data
);
  import chd_pkg::*;

  logic [3:0]           phase_r, phase_nxt;
  line_state_t          lst_r, lst_nxt;
  logic                 crp_r, crp_nxt;
  logic [SIZE_BITS-1:0] rem_r, rem_nxt;
  logic [2:0]           fault_r, fault_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;
  logic                 produce;
  out_item_t            res;
  logic [7:0]           b;

  assign stg_take  = stg_valid && (!out_valid_r || out_ready);
  assign lst       = lst_r;
  assign crp       = crp_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign b         = stg_item.body_byte;

  always_comb begin
    phase_nxt = phase_r;
    lst_nxt   = lst_r;
    crp_nxt   = crp_r;
    rem_nxt   = rem_r;
    fault_nxt = fault_r;
    produce   = 1'b0;
    res       = '0;

    if (stg_item.end_of_body) begin
      produce = 1'b1;
      if (phase_r == PH_FAILED) begin
        res.result_kind = KIND_BAD;
        res.fault_code  = fault_r;
      end else if (phase_r == PH_DONE || phase_r == PH_LINE_START) begin
        res.result_kind = KIND_OK;
      end else begin
        res.result_kind = KIND_BAD;
        res.fault_code  = FAULT_TRUNCATED;
      end
      phase_nxt = PH_LINE_START;
      lst_nxt   = '0;
      crp_nxt   = 1'b0;
      fault_nxt = FAULT_NONE;
    end else begin
      case (phase_r)
        PH_LINE_START, PH_SIZE_LINE: begin
          phase_nxt = PH_SIZE_LINE;
          crp_nxt   = pr.crp_nxt;
          lst_nxt   = pr.lst_nxt;
          if (pr.line_done) begin
            lst_nxt = '0;
            case (pr.line_code)
              LE_BAD: begin
                fault_nxt = FAULT_BAD_SIZE;
                phase_nxt = PH_FAILED;
              end
              LE_OVER: begin
                fault_nxt = FAULT_OVERFLOW;
                phase_nxt = PH_FAILED;
              end
              LE_ZERO: begin
                phase_nxt = PH_ZERO_CR;
              end
              default: begin
                rem_nxt   = lst_r.acc;
                phase_nxt = PH_DATA;
              end
            endcase
          end
        end
        PH_DATA: begin
          produce          = 1'b1;
          res.result_kind  = KIND_PAYLOAD;
          res.payload_byte = b;
          rem_nxt          = rem_r - 1'b1;
          if (rem_r == {{(SIZE_BITS-1){1'b0}}, 1'b1}) begin
            phase_nxt = PH_DATA_CR;
          end
        end
        PH_DATA_CR: begin
          if (b == CH_CR) begin
            phase_nxt = PH_DATA_LF;
          end else begin
            fault_nxt = FAULT_DATA_CRLF;
            phase_nxt = PH_FAILED;
          end
        end
        PH_DATA_LF: begin
          if (b == CH_LF) begin
            phase_nxt = PH_LINE_START;
          end else begin
            fault_nxt = FAULT_DATA_CRLF;
            phase_nxt = PH_FAILED;
          end
        end
        PH_ZERO_CR: begin
          if (b == CH_CR) begin
            phase_nxt = PH_ZERO_LF;
          end else begin
            fault_nxt = FAULT_ZERO_CRLF;
            phase_nxt = PH_FAILED;
          end
        end
        PH_ZERO_LF: begin
          if (b == CH_LF) begin
            phase_nxt = PH_DONE;
          end else begin
            fault_nxt = FAULT_ZERO_CRLF;
            phase_nxt = PH_FAILED;
          end
        end
        default: begin
          // Done or failed: bytes are dropped until the end marker.
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (stg_take) begin
      out_valid_nxt = produce;
      out_data_nxt  = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LINE_START;
      lst_r       <= '0;
      crp_r       <= 1'b0;
      fault_r     <= FAULT_NONE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (stg_take) begin
        phase_r <= phase_nxt;
        lst_r   <= lst_nxt;
        crp_r   <= crp_nxt;
        fault_r <= fault_nxt;
      end
    end
    if (stg_take) begin
      rem_r <= rem_nxt;
    end
    out_data_r <= out_data_nxt;
  end

endmodule

// File: hdl/http_chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Chunked transfer body decoder: size lines, payload bytes, final status.
// ----------------------------------------------------------------------------
//   Channel | Ports                       | Carries
//   in      | in_valid/in_ready/in_data   | body byte or end marker
//   out     | out_valid/out_ready/out_data| payload byte or final status
//
// One item is taken per clock while the result channel does not stall; a
// result passes from its input transfer through the input register, then the
// phase logic into the result register, before it can transfer out.
// Size line bytes, CR LF checks and dropped bytes produce no result.
// rst_n is synchronous; after reset the decoder waits at a line start.
// A stalled result holds in the result register while the input register
// still takes one more item.
module http_chunked_body_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  chd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output chd_pkg::out_item_t out_data
);
  import chd_pkg::*;

  logic        stg_valid;
  in_item_t    stg_item;
  logic        stg_take;
  parse_t      pr;
  line_state_t lst;
  logic        crp;

  chd_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .stg_valid (stg_valid),
    .stg_item  (stg_item),
    .stg_take  (stg_take)
  );

  chd_size_parser u_size_parser (
    .body_byte (stg_item.body_byte),
    .lst_r     (lst),
    .crp_r     (crp),
    .pr        (pr)
  );

  chd_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .stg_valid (stg_valid),
    .stg_item  (stg_item),
    .stg_take  (stg_take),
    .pr        (pr),
    .lst       (lst),
    .crp       (crp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: hdl/chd_checker.sv
// ----------------------------------------------------------------------------
// chd_checker
// Port level checks on the decoder's result channel.
// ----------------------------------------------------------------------------
module chd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input chd_pkg::out_item_t out_data
);
  import chd_pkg::*;

  // A stalled result must hold until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == KIND_PAYLOAD |-> out_data.fault_code == FAULT_NONE)
    else $error("payload result carries a fault code");

  a_ok_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == KIND_OK
      |-> out_data.fault_code == FAULT_NONE && out_data.payload_byte == 8'd0)
    else $error("ok status carries data");

  a_bad_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == KIND_BAD
      |-> out_data.fault_code != FAULT_NONE && out_data.fault_code <= FAULT_TRUNCATED
          && out_data.payload_byte == 8'd0)
    else $error("malformed status without a valid fault code");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind http_chunked_body_decoder chd_checker u_chd_checker (.*);

// File: verif/http_chunked_body_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_tb
// Streams chunked bodies into the decoder, byte by byte, each closed by an
// end marker. A mirror of the decoder state predicts every payload byte and
// final status, and each result transfer is compared field by field.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_tb;
  import chd_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam int          CYCLE_LIMIT = 400000;
  localparam logic [63:0] SIZE_MAX    = (64'd1 << SIZE_BITS) - 64'd1;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Decoder mirror used for prediction.
  logic [3:0]  dec_phase;
  logic [63:0] dec_size;
  logic [63:0] dec_left;
  logic [2:0]  dec_fault;
  bit          dec_cr_held;
  bit          sz_digits, sz_sign, sz_stop, sz_semi, sz_neg, sz_over, sz_lone_zero;

  out_item_t expected_results[$];
  int        error_count = 0;
  int        item_count = 0;
  int        cycle_count = 0;
  bit        quiet = 1'b0;

  http_chunked_body_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Decoder mirror
  // ---------------------------------------------------------------------------
  task automatic clear_decoder();
    dec_phase   = PH_LINE_START;
    dec_size    = '0;
    dec_left    = '0;
    dec_fault   = FAULT_NONE;
    dec_cr_held = 1'b0;
    {sz_digits, sz_sign, sz_stop, sz_semi, sz_neg, sz_over, sz_lone_zero} = '0;
  endtask

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic bit is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  task automatic record_fault(input logic [2:0] code);
    dec_fault = code;
    dec_phase = PH_FAILED;
  endtask

  task automatic scan_size_char(input logic [7:0] c);
    int d;
    if (sz_stop || sz_semi) return;
    if (c == CH_SEMI) begin
      sz_semi = 1'b1;
      return;
    end
    d = hex_digit(c);
    if (!sz_digits) begin
      if (!sz_sign) begin
        if (is_space(c)) return;
        if (c == "+" || c == "-") begin
          sz_sign = 1'b1;
          sz_neg  = (c == "-");
          return;
        end
      end
      if (d < 0) begin
        sz_stop = 1'b1;
        return;
      end
      sz_digits    = 1'b1;
      sz_lone_zero = (d == 0);
      dec_size     = 64'(d);
      return;
    end
    // An x right after a single leading zero is the hex prefix.
    if (sz_lone_zero && (c == "x" || c == "X")) begin
      sz_lone_zero = 1'b0;
      return;
    end
    sz_lone_zero = 1'b0;
    if (d < 0) begin
      sz_stop = 1'b1;
      return;
    end
    if (sz_over) return;
    if (dec_size > (SIZE_MAX >> 4)) begin
      sz_over = 1'b1;
      return;
    end
    dec_size = (dec_size << 4) | 64'(d);
    if (dec_size > SIZE_MAX) sz_over = 1'b1;
  endtask

  task automatic finish_size_line();
    bit          had_digits, was_neg, was_over;
    logic [63:0] value;
    had_digits = sz_digits;
    was_neg    = sz_neg;
    was_over   = sz_over;
    value      = dec_size;
    {sz_digits, sz_sign, sz_stop, sz_semi, sz_neg, sz_over, sz_lone_zero} = '0;
    dec_size = '0;
    if (!had_digits) record_fault(FAULT_BAD_SIZE);
    else if (was_over) record_fault(FAULT_OVERFLOW);
    else if (value == 0) dec_phase = PH_ZERO_CR;
    else if (was_neg) record_fault(FAULT_BAD_SIZE);
    else begin
      dec_left  = value;
      dec_phase = PH_DATA;
    end
  endtask

  task automatic decode_step(input in_item_t it, output bit emits, output out_item_t res);
    logic [7:0] b;
    b       = it.body_byte;
    res     = '0;
    emits   = 1'b0;
    if (it.end_of_body) begin
      emits = 1'b1;
      if (dec_phase == PH_FAILED) begin
        res.result_kind = KIND_BAD;
        res.fault_code  = dec_fault;
      end else if (dec_phase == PH_DONE || dec_phase == PH_LINE_START) begin
        res.result_kind = KIND_OK;
      end else begin
        res.result_kind = KIND_BAD;
        res.fault_code  = FAULT_TRUNCATED;
      end
      clear_decoder();
      return;
    end
    case (dec_phase)
      PH_LINE_START, PH_SIZE_LINE: begin
        dec_phase = PH_SIZE_LINE;
        // A CR only ends the line when LF follows; otherwise it is scanned as a line character.
        if (dec_cr_held) begin
          dec_cr_held = 1'b0;
          if (b == CH_LF) begin
            finish_size_line();
            return;
          end
          scan_size_char(CH_CR);
        end
        if (b == CH_CR) dec_cr_held = 1'b1;
        else scan_size_char(b);
      end
      PH_DATA: begin
        emits = 1'b1;
        res.result_kind  = KIND_PAYLOAD;
        res.payload_byte = b;
        dec_left = dec_left - 64'd1;
        if (dec_left == 0) dec_phase = PH_DATA_CR;
      end
      PH_DATA_CR: if (b == CH_CR) dec_phase = PH_DATA_LF; else record_fault(FAULT_DATA_CRLF);
      PH_DATA_LF: if (b == CH_LF) dec_phase = PH_LINE_START; else record_fault(FAULT_DATA_CRLF);
      PH_ZERO_CR: if (b == CH_CR) dec_phase = PH_ZERO_LF; else record_fault(FAULT_ZERO_CRLF);
      PH_ZERO_LF: if (b == CH_LF) dec_phase = PH_DONE; else record_fault(FAULT_ZERO_CRLF);
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: kind %0d byte %0d fault %0d",
               out_data.result_kind, out_data.payload_byte, out_data.fault_code);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.result_kind !== want.result_kind) begin
          $error("result_kind: expected %0d, actual %0d", want.result_kind,
                 out_data.result_kind);
          error_count++;
        end
        if (out_data.payload_byte !== want.payload_byte) begin
          $error("payload_byte: expected %0d, actual %0d", want.payload_byte,
                 out_data.payload_byte);
          error_count++;
        end
        if (out_data.fault_code !== want.fault_code) begin
          $error("fault_code: expected %0d, actual %0d", want.fault_code,
                 out_data.fault_code);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [7:0] b, input logic eob);
    in_item_t  it;
    out_item_t res;
    bit        emits;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    it.body_byte   = b;
    it.end_of_body = eob;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    decode_step(it, emits, res);
    if (emits) expected_results.insert(expected_results.size(), res);
    item_count++;
  endtask

  // Sends the body and then the end marker, whose byte is don't-care.
  task automatic send_body(input byte_q_t q);
    foreach (q[i]) send_item(q[i], 1'b0);
    send_item(8'($urandom), 1'b1);
  endtask

  task automatic put_text(ref byte_q_t q, input string s);
    for (int i = 0; i < s.len(); i++) q.insert(q.size(), s[i]);
  endtask

  task automatic send_text(input string s);
    byte_q_t q;
    put_text(q, s);
    send_body(q);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Size line in one of the legal spellings.
  task automatic put_size_line(ref byte_q_t q, input logic [63:0] sz);
    string digits;
    digits = $sformatf("%0h", sz);
    if ($urandom_range(0, 1)) digits = digits.toupper();
    case ($urandom_range(0, 3))
      0: put_text(q, " ");
      1: put_text(q, "\t");
      default: ;
    endcase
    if ($urandom_range(0, 4) == 0) put_text(q, (sz == 0 && $urandom_range(0, 1)) ? "-" : "+");
    case ($urandom_range(0, 5))
      0: put_text(q, "0x");
      1: put_text(q, "0X");
      2: put_text(q, "00");
      default: ;
    endcase
    put_text(q, digits);
    case ($urandom_range(0, 5))
      0: put_text(q, ";name=val");
      1: put_text(q, " ;x");
      2: put_text(q, "\rq");
      default: ;
    endcase
    put_text(q, "\r\n");
  endtask

  task automatic make_random_body(output byte_q_t q);
    int          kind, n;
    logic [63:0] sz;
    q = {};
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 12)) q.insert(q.size(), 8'($urandom));
      return;
    end
    repeat ($urandom_range(0, 3)) begin
      sz = $urandom_range(1, 6);
      if ($urandom_range(0, 7) == 0) sz = $urandom_range(7, 40);
      put_size_line(q, sz);
      repeat (sz) q.insert(q.size(), 8'($urandom));
      put_text(q, "\r\n");
    end
    if ($urandom_range(0, 5) != 0) begin
      put_size_line(q, 64'd0);
      put_text(q, "\r\n");
    end
    if (kind == 1) repeat ($urandom_range(1, 4)) q.insert(q.size(), 8'($urandom));
    if (kind >= 7) begin
      case ($urandom_range(0, 4))
        0: if (q.size() > 0) q[$urandom_range(0, q.size() - 1)] = 8'($urandom);
        1: begin
          n = (q.size() > 0) ? $urandom_range(0, q.size() - 1) : 0;
          while (q.size() > n) q.delete(q.size() - 1);
        end
        2: q.insert($urandom_range(0, q.size()), 8'($urandom));
        3: begin
          // At least nine hex digits with a nonzero lead: always too large.
          q = {};
          if ($urandom_range(0, 1)) put_text(q, "-");
          put_text(q, $sformatf("%0h%08h\r\n", $urandom_range(1, 255), $urandom));
        end
        default: begin
          q = {};
          put_text(q, $urandom_range(0, 1) ? "ffffffff\r\n" : "FFFFFFFF;max\r\n");
          repeat ($urandom_range(0, 5)) q.insert(q.size(), 8'($urandom));
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_basic_bodies();
    send_text("");
    send_text("1\r\nA\r\n0\r\n\r\n");
  endtask

  task automatic test_size_line_forms();
    byte_q_t q;
    put_text(q, " \t+0X2;ext=1\r\n");
    q.insert(q.size(), 8'hff);
    q.insert(q.size(), 8'h00);
    // Lone CR after the digits of a size line stops the scan.
    put_text(q, "\r\n2\rz\r\n");
    q.insert(q.size(), 8'h5a);
    q.insert(q.size(), 8'ha5);
    put_text(q, "\r\n0x\r\n\r\nQQ");
    send_body(q);
  endtask

  task automatic test_size_faults();
    send_text("\r\n");
    send_text("-5\r\n");
    send_text("-0\r\n\r\n");
    send_text("100000000\r\n");
    send_text("-100000000\r\n");
  endtask

  task automatic test_framing_faults();
    send_text("1\r\nAzz\r\n");
    send_text("1\r\nA\rz");
    send_text("0\r\nX");
    send_text("0\r\n\rX");
  endtask

  task automatic test_truncation();
    send_text("ffffffff\r\nAB");
    send_text("1f");
    send_text("1\r\nA\r");
  endtask

  // Random bodies until the total item count reaches the target.
  task automatic test_random_bodies(input int target);
    byte_q_t q;
    while (item_count < target) begin
      quiet = (item_count >= target - 100);
      make_random_body(q);
      send_body(q);
      if (!quiet && $urandom_range(0, 24) == 0) wait_for_drain();
    end
  endtask

  initial begin
    clear_decoder();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_bodies();
    test_size_line_forms();
    wait_for_drain();
    test_size_faults();
    test_framing_faults();
    test_truncation();
    test_random_bodies(500);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// File: filelist.f
hdl/chd_pkg.sv
hdl/chd_in_stage.sv
hdl/chd_size_parser.sv
hdl/chd_engine.sv
hdl/http_chunked_body_decoder.sv
hdl/chd_checker.sv
verif/http_chunked_body_decoder_tb.sv
